### sv/grma_pkg.sv
// types, constants and codes shared by the glitch rejecting moving average
// no dependencies
`timescale 1ns / 1ps

package grma_pkg;

  localparam int DATA_W         = 16;
  localparam int LEN_REG_W      = 6;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int DEF_MAX_WINDOW = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_STEP   = 1'b1;

  localparam logic [LEN_REG_W-1:0] WINDOW_LEN_RESET = 6'd5;
  localparam logic [DATA_W-1:0]    MAX_STEP_RESET   = 16'd150;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic div_last;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

### sv/glitch_rejecting_moving_average.sv
// top level of the glitch rejecting moving average
// depends on grma_pkg, grma_ctrl, grma_datapath
//
//  channel   dir   signals                       payload
//  s         in    s_tvalid s_tready s_tdata     sample [15:0]
//  m         out   m_tvalid m_tready m_tdata     average [15:0]
//  cfg       in    cfg_we cfg_addr cfg_data      0 window_len [5:0], 1 max_step [15:0]
//
// a sample that seeds or is rejected skips the divide and goes straight to the result
// an accepted sample's average comes from the one-bit-per-cycle restoring divide
// of the window sum by the window length
// one request in flight; the next is taken while a result waits on m
// rst is synchronous; after reset the block is unseeded with length 5, step 150
`timescale 1ns / 1ps

module glitch_rejecting_moving_average #(
  parameter int MAX_WINDOW = grma_pkg::DEF_MAX_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [grma_pkg::DATA_W-1:0]     s_tdata,   // [15:0] sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [grma_pkg::DATA_W-1:0]     m_tdata,   // [15:0] average
  input  logic                            cfg_we,
  input  logic [grma_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [grma_pkg::CFG_DATA_W-1:0] cfg_data
);
  import grma_pkg::*;

  cmd_t    cmd;
  status_t status;

  grma_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  grma_datapath #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .sample   (s_tdata),
    .average  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

### sv/grma_ctrl.sv
// sequencer for the moving average: request intake, divide count, result handoff
// depends on grma_pkg
`timescale 1ns / 1ps

module grma_ctrl #(
  parameter int MAX_WINDOW = grma_pkg::DEF_MAX_WINDOW
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  grma_pkg::status_t status,
  output grma_pkg::cmd_t    cmd
);
  import grma_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid, out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cnt_next = '0;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = status.need_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          cmd.div_last = 1'b1;
          state_next   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwritten while still pending");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.need_div) |=> (state == ST_DIV && cnt == '0))
    else $error("divide not started after accepted sample");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    cmd.div_last |-> (state == ST_DIV && $past(cmd.div_step)))
    else $error("divide finished without full step sequence");

endmodule

### sv/grma_datapath.sv
// window taps, running sum, acceptance check, serial divider and result register
// depends on grma_pkg
`timescale 1ns / 1ps

module grma_datapath #(
  parameter int MAX_WINDOW = grma_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [grma_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [grma_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [grma_pkg::DATA_W-1:0]         sample,
  output logic [grma_pkg::DATA_W-1:0]         average,
  input  grma_pkg::cmd_t                      cmd,
  output grma_pkg::status_t                   status
);
  import grma_pkg::*;

  localparam int SUM_W = DATA_W + $clog2(MAX_WINDOW);
  localparam int LU_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = DATA_W + 2;

  logic [LEN_REG_W-1:0] window_len;
  logic [DATA_W-1:0]    max_step;
  logic [DATA_W-1:0]    window [MAX_WINDOW];
  logic                 seeded;
  logic [LU_W-1:0]      len_used;
  logic [DATA_W-1:0]    last_average;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     dvd;
  logic [LU_W-1:0]      rem;
  logic [DATA_W-1:0]    out_data;

  logic [6:0]           eff7;
  logic [LU_W-1:0]      len_eff;
  logic [DATA_W-1:0]    newest;
  logic signed [CMP_W-1:0] sv, nv, mv, n_lo, n_hi;
  logic                 ok;
  logic                 do_seed, do_shift;
  logic [SUM_W-1:0]     sum_shift;
  logic [SUM_W-1:0]     sum_seed;
  logic [LU_W:0]        rem_sh;
  logic                 q_bit;
  logic [LU_W-1:0]      rem_next;
  logic [SUM_W-1:0]     dvd_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
      max_step   <= MAX_STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW_LEN: window_len <= cfg_data[LEN_REG_W-1:0];
        REG_MAX_STEP:   max_step   <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp length to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      eff7 = 7'd1;
    end else if ({1'b0, window_len} > 7'(MAX_WINDOW)) begin
      eff7 = 7'(MAX_WINDOW);
    end else begin
      eff7 = {1'b0, window_len};
    end
    len_eff = LU_W'(eff7);
  end

  always_comb begin
    newest = window[0];
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (LU_W'(i + 1) == len_used) begin
        newest = window[i];
      end
    end
  end

  always_comb begin
    sv   = signed'({2'b00, sample});
    nv   = signed'({2'b00, newest});
    mv   = signed'({2'b00, max_step});
    n_lo = nv - mv;
    n_hi = nv + mv;
    ok   = (sv >= mv && sv > n_lo && sv < n_hi) ||
           (sv <= mv && sv > 0 && sv < n_hi);
  end

  assign do_seed         = cmd.accept && !seeded;
  assign do_shift        = cmd.accept && seeded && ok;
  assign status.need_div = seeded && ok;

  assign sum_shift = sum - SUM_W'(window[0]) + SUM_W'(sample);
  assign sum_seed  = SUM_W'(SUM_W'(sample) * SUM_W'(len_eff));

  // window taps, oldest at index 0, newest at len_used-1
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_tap
    logic [DATA_W-1:0] upper;
    if (g == MAX_WINDOW - 1) begin : g_end
      assign upper = sample;
    end else begin : g_mid
      assign upper = window[g + 1];
    end
    always_ff @(posedge clk) begin
      if (do_seed) begin
        window[g] <= sample;
      end else if (do_shift) begin
        if (LU_W'(g + 1) < len_used) begin
          window[g] <= upper;
        end else if (LU_W'(g + 1) == len_used) begin
          window[g] <= sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded       <= 1'b0;
      len_used     <= LU_W'(1);
      last_average <= '0;
    end else if (do_seed) begin
      seeded       <= (len_eff != LU_W'(1));
      len_used     <= len_eff;
      last_average <= sample;
    end else if (cmd.accept && seeded && !ok) begin
      seeded <= 1'b0;
    end else if (cmd.div_last) begin
      last_average <= dvd_next[DATA_W-1:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, dvd[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, len_used});
    if (q_bit) begin
      rem_next = LU_W'(rem_sh - {1'b0, len_used});
    end else begin
      rem_next = rem_sh[LU_W-1:0];
    end
    dvd_next = {dvd[SUM_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (do_seed) begin
      sum <= sum_seed;
    end else if (do_shift) begin
      sum <= sum_shift;
    end
    if (do_shift) begin
      dvd <= sum_shift;
      rem <= '0;
    end else if (cmd.div_step) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
    if (cmd.out_load) begin
      out_data <= last_average;
    end
  end

  assign average = out_data;

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < len_used))
    else $error("divider remainder out of range");

endmodule

### tb/sv/grma_average_checker.sv
// checker for the glitch rejecting moving average: watches the sample, result
// and register channels, predicts each average and compares it on arrival
// depends on grma_pkg
`timescale 1ns / 1ps

module grma_average_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [grma_pkg::DATA_W-1:0]     s_tdata,   // [15:0] sample
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [grma_pkg::DATA_W-1:0]     m_tdata,   // [15:0] average
  input  logic                            cfg_we,
  input  logic [grma_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [grma_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              error_count,
  output int                              pending_count
);

  import grma_pkg::*;

  localparam int WIN_MAX = DEF_MAX_WINDOW;

  logic [LEN_REG_W-1:0] win_len_reg;
  logic [DATA_W-1:0]    max_step_reg;
  logic [DATA_W-1:0]    sample_store [WIN_MAX];
  logic                 seeded;
  logic [DATA_W-1:0]    held_average;
  int unsigned          len_latched;
  logic [DATA_W-1:0]    expected_averages [$];
  int                   err_total;

  initial begin
    err_total = 0;
  end

  function automatic logic [DATA_W-1:0] filter_sample(input logic [DATA_W-1:0] smp);
    int unsigned n;
    int unsigned total;
    int          newest;
    int          sv;
    int          ms;
    logic        ok;
    if (!seeded) begin
      n = (win_len_reg == 0) ? 1 : ((win_len_reg > WIN_MAX) ? WIN_MAX : win_len_reg);
      for (int i = 0; i < n; i++) sample_store[i] = smp;
      len_latched  = n;
      seeded       = (n != 1);
      held_average = smp;
    end else begin
      n = len_latched;
      if (n < 1 || n > WIN_MAX) n = 1;
      newest = int'(sample_store[n-1]);
      sv     = int'(smp);
      ms     = int'(max_step_reg);
      ok = (sv >= ms && sv > newest - ms && sv < newest + ms) ||
           (sv <= ms && sv > 0 && sv < newest + ms);
      if (ok) begin
        for (int i = 0; i + 1 < n; i++) sample_store[i] = sample_store[i+1];
        sample_store[n-1] = smp;
        total = 0;
        for (int i = 0; i < n; i++) total += sample_store[i];
        held_average = DATA_W'(total / n);
      end else begin
        seeded = 1'b0;
      end
    end
    return held_average;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      win_len_reg  = WINDOW_LEN_RESET;
      max_step_reg = MAX_STEP_RESET;
      seeded       = 1'b0;
      held_average = '0;
      len_latched  = 1;
      expected_averages.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_averages.size() == 0) begin
          err_total++;
          if (err_total <= 100)
            $display("%0t: result with no pending request, expected none, got %h",
                     $time, m_tdata);
        end else begin
          want = expected_averages.pop_front();
          if (m_tdata !== want) begin
            err_total++;
            if (err_total <= 100)
              $display("%0t: average mismatch, expected %h, got %h", $time, want, m_tdata);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_WINDOW_LEN) win_len_reg = cfg_data[LEN_REG_W-1:0];
        else if (cfg_addr == REG_MAX_STEP) max_step_reg = cfg_data[DATA_W-1:0];
      end
      if (s_tvalid && s_tready) expected_averages.push_back(filter_sample(s_tdata));
    end
    error_count   <= err_total;
    pending_count <= expected_averages.size();
  end

endmodule

### tb/sv/tb_glitch_rejecting_moving_average.sv
// testbench top for the glitch rejecting moving average: drives samples and
// register writes, paces the result side and gives the verdict
// depends on grma_pkg, grma_average_checker, glitch_rejecting_moving_average
`timescale 1ns / 1ps

module tb_glitch_rejecting_moving_average;

  import grma_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 130;
  localparam int LONG_HOLD    = 500;
  localparam int HOLD_AT      = 300;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;     // [15:0] sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;          // [15:0] average
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    error_count;
  int                    pending_count;
  int                    cycle_cnt;
  int unsigned           cur_step = MAX_STEP_RESET;
  logic [DATA_W-1:0]     last_sample = '0;
  bit                    send_burst = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  glitch_rejecting_moving_average DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  grma_average_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  task automatic send_sample(input logic [DATA_W-1:0] v);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    last_sample = v;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // register writes only once every request has its result
  task automatic apply_settings(input int unsigned len, input int unsigned step);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_WINDOW_LEN, CFG_DATA_W'(len));
    write_reg(REG_MAX_STEP, CFG_DATA_W'(step));
    cfg_we   <= 1'b0;
    cur_step = step;
  endtask

  function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] base,
                                                    input int unsigned step);
    int roll;
    int w;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      // mostly close to the newest sample so the window keeps filling
      w = (step == 0) ? 0 : int'(step) - 1;
      if ($urandom_range(0, 3) == 0 && w > 20) w = 20;
      if ($urandom_range(0, 9) == 0)
        v = ($urandom_range(0, 1) == 0) ? int'(base) - int'(step) : int'(base) + int'(step);
      else
        v = int'(base) + int'($urandom_range(0, 2 * w)) - w;
    end else if (roll < 80) begin
      v = int'($urandom_range(0, (step >= 65535) ? 65535 : step + 1));
    end else if (roll < 90) begin
      case ($urandom_range(0, 5))
        0: v = 0;
        1: v = 65535;
        2: v = int'(step);
        3: v = int'(step) - 1;
        4: v = int'(step) + 1;
        default: v = int'(base);
      endcase
    end else begin
      v = int'($urandom_range(0, 65535));
    end
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return DATA_W'(v);
  endfunction

  // result side, with one long hold-off so the block backs up its input
  initial begin
    int  wait_cycles;
    int  results_seen;
    bit  recv_burst;
    bit  held_once;
    results_seen = 0;
    recv_burst   = 1'b0;
    held_once    = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      wait_cycles = recv_burst ? 0 : $urandom_range(0, 11);
      if (!held_once && results_seen == HOLD_AT) begin
        wait_cycles = LONG_HOLD;
        held_once   = 1'b1;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_seen++;
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_glitch_rejecting_moving_average: done, errors");
    $finish;
  end

  initial begin
    static logic [DATA_W-1:0] reset_run [$] = '{16'd0, 16'd65535, 16'd65535, 16'd65535,
                                                16'd65400, 16'd65251, 16'd65250, 16'd0,
                                                16'd150, 16'd299, 16'd300, 16'd149,
                                                16'd1, 16'd0, 16'd1};
    static logic [DATA_W-1:0] len_one_run [$] = '{16'd65535, 16'd0, 16'd12345};
    static logic [DATA_W-1:0] len_zero_run [$] = '{16'd7, 16'd9};
    static logic [DATA_W-1:0] len_sat_run [$] = '{16'd65535, 16'd0, 16'd65535, 16'd1};
    static logic [DATA_W-1:0] relen_run [$] = '{16'd40000, 16'd30000};
    static int unsigned phase_len [12] = '{5, 1, 0, 32, 63, 2, 3, 16, 32, 8, 0, 0};
    static int unsigned phase_step [12] = '{150, 300, 50, 2000, 65535, 0, 1, 150, 64,
                                            40000, 0, 0};
    int unsigned len;
    int unsigned step;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, extremes and both acceptance branches
    foreach (reset_run[i]) send_sample(reset_run[i]);
    apply_settings(1, 150);
    foreach (len_one_run[i]) send_sample(len_one_run[i]);
    apply_settings(0, 150);
    foreach (len_zero_run[i]) send_sample(len_zero_run[i]);
    apply_settings(63, 65535);
    foreach (len_sat_run[i]) send_sample(len_sat_run[i]);
    // new length while seeded only applies at the next seeding
    apply_settings(2, 65535);
    foreach (relen_run[i]) send_sample(relen_run[i]);

    for (int p = 0; p < 12; p++) begin
      len  = phase_len[p];
      step = phase_step[p];
      if (p == 10) begin
        len  = $urandom_range(0, 63);
        step = $urandom_range(0, 3000);
      end else if (p == 11) begin
        len  = $urandom_range(0, 63);
        step = $urandom_range(0, 65535);
      end
      apply_settings(len, step);
      for (int k = 0; k < PHASE_ITEMS; k++) send_sample(pick_sample(last_sample, cur_step));
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("tb_glitch_rejecting_moving_average: done, clean");
    else
      $display("tb_glitch_rejecting_moving_average: done, errors");
    $finish;
  end

endmodule
